### rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants for the line editor buffer
// Sequencer states, decoded key actions, register indexes, fixed codes.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int CHAR_W = 8;   // character code width
  localparam int POS_W  = 7;   // cursor / length field width on the result

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;

  localparam logic [CHAR_W-1:0] BACKSPACE_RST = 8'd8;
  localparam logic [CHAR_W-1:0] DELETE_RST    = 8'd19;
  localparam logic [CHAR_W-1:0] LEFT_RST      = 8'd18;
  localparam logic [CHAR_W-1:0] RIGHT_RST     = 8'd17;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BACKSPACE = 2'd0,
    REG_DELETE    = 2'd1,
    REG_LEFT      = 2'd2,
    REG_RIGHT     = 2'd3
  } reg_idx_t;

  // what one key code asks for, after priority decode
  typedef enum logic [2:0] {
    ACT_BS,
    ACT_DEL,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_NL,
    ACT_CHAR,
    ACT_NONE
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOVE,
    ST_INS_WR,
    ST_LINE_RD,
    ST_LINE_OUT,
    ST_STATUS_RD,
    ST_STATUS_OUT
  } state_t;

endpackage

### rtl/leb_store.sv
// ----------------------------------------------------------------------------
// leb_store: line character memory
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module leb_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/line_editor_buffer.sv
// ----------------------------------------------------------------------------
// line_editor_buffer: terminal style line editor
// Holds one text line with a cursor; edits it key by key and emits the line
// on newline.
//
// Usage:
//  - s_* takes one key code per item (s_tdata = key_char). s_tready is high
//    only while the sequencer is idle; one item is worked on at a time.
//  - m_* gives results. A status item (m_tuser = 0) follows every key except
//    newline. A newline yields one item per line character (m_tuser = 1),
//    newline included, with m_tlast on the final one.
//  - cfg_we/cfg_index/cfg_data write the backspace, delete, left and right
//    codes; write only while the block is idle.
// Timing: backspace, delete, character insert and newline shift the tail of
//  the line through the store, one character per cycle. For the edit keys a
//  status item follows the shift; a newline is followed by its line output.
//  Line items go out one per cycle while the receiver keeps m_tready high.
// Stalls: the output register holds its item until taken; the block can
//  accept the next key meanwhile but stops before its own result.
// Reset: cursor and length go to zero, codes to 8/19/18/17. The store itself
//  is not cleared; entries beyond the length are never used.
// ----------------------------------------------------------------------------
module line_editor_buffer
  import leb_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // key input: [7:0] key_char
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // results: [7:0] char_value, [14:8] cursor_pos, [21:15] line_length,
  //          [22] overflow, [23] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // [0] kind
  output logic        m_tuser,
  // last
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(LINE_CAPACITY - 1);
  localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

  // editing codes
  logic [CHAR_W-1:0] bs_code, del_code, left_code, right_code;

  state_t state, state_next;

  logic [CHAR_W-1:0] code, code_next;
  logic [CNT_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  length, length_next;
  logic              ovf, ovf_next;

  // tail shift sequencer
  logic [CNT_W-1:0]  mv_cnt, mv_cnt_next;
  logic              mv_ins, mv_ins_next;
  logic              wr_pend, wr_pend_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              mv_more;

  // line output index
  logic [CNT_W-1:0]  line_idx, line_idx_next;
  logic              line_last;

  // store port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic              out_valid;
  logic              slot_free, load_out;
  logic              o_kind, o_kind_next;
  logic [CHAR_W-1:0] o_char, o_char_next;
  logic [POS_W-1:0]  o_cur, o_cur_next;
  logic [POS_W-1:0]  o_len, o_len_next;
  logic              o_ovf, o_ovf_next;
  logic              o_last, o_last_next;

  act_t act;

  leb_store #(
    .DEPTH (LINE_CAPACITY),
    .WIDTH (CHAR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ports
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {1'b0, o_ovf, o_len, o_cur, o_char};

  assign slot_free = !out_valid || m_tready;

  // key decode, first matching register wins
  always_comb begin
    priority if (code == bs_code)    act = ACT_BS;
    else if (code == del_code)       act = ACT_DEL;
    else if (code == left_code)      act = ACT_LEFT;
    else if (code == right_code)     act = ACT_RIGHT;
    else if (code == NEWLINE_CODE)   act = ACT_NL;
    else if (code != NUL_CODE)       act = ACT_CHAR;
    else                             act = ACT_NONE;
  end

  // insert walks down from length to cursor; remove walks up to new length
  assign mv_more   = mv_ins ? (mv_cnt > cursor) : (mv_cnt <= length);
  assign line_last = ((line_idx + ONE) == length);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (act)
          ACT_BS:    state_next = (cursor != '0) ? ST_MOVE : ST_STATUS_RD;
          ACT_DEL:   state_next = (cursor < length) ? ST_MOVE : ST_STATUS_RD;
          ACT_NL:    state_next = ST_MOVE;
          ACT_CHAR:  state_next = (length < CAP_M1) ? ST_MOVE : ST_STATUS_RD;
          default:   state_next = ST_STATUS_RD;
        endcase
      end
      ST_MOVE: begin
        if (!mv_more) state_next = mv_ins ? ST_INS_WR : ST_STATUS_RD;
      end
      ST_INS_WR: begin
        state_next = (act == ACT_NL) ? ST_LINE_RD : ST_STATUS_RD;
      end
      ST_LINE_RD:    state_next = ST_LINE_OUT;
      ST_LINE_OUT: begin
        if (slot_free && line_last) state_next = ST_IDLE;
      end
      ST_STATUS_RD:  state_next = ST_STATUS_OUT;
      ST_STATUS_OUT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    code_next     = code;
    cursor_next   = cursor;
    length_next   = length;
    ovf_next      = ovf;
    mv_cnt_next   = mv_cnt;
    mv_ins_next   = mv_ins;
    wr_pend_next  = wr_pend;
    wr_addr_next  = wr_addr;
    line_idx_next = line_idx;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    load_out      = 1'b0;
    o_kind_next   = 1'b0;
    o_char_next   = '0;
    o_cur_next    = '0;
    o_len_next    = '0;
    o_ovf_next    = 1'b0;
    o_last_next   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          code_next = s_tdata;
          ovf_next  = 1'b0;
        end
      end
      ST_DECODE: begin
        wr_pend_next = 1'b0;
        unique case (act)
          ACT_BS: begin
            if (cursor != '0) begin
              // remove at cursor-1: pull cursor..len-1 down by one
              cursor_next = cursor - ONE;
              length_next = length - ONE;
              mv_cnt_next = cursor;
              mv_ins_next = 1'b0;
            end
          end
          ACT_DEL: begin
            if (cursor < length) begin
              length_next = length - ONE;
              mv_cnt_next = cursor + ONE;
              mv_ins_next = 1'b0;
            end
          end
          ACT_LEFT: begin
            if (cursor != '0) cursor_next = cursor - ONE;
          end
          ACT_RIGHT: begin
            if (cursor < length) cursor_next = cursor + ONE;
          end
          ACT_NL: begin
            mv_cnt_next = length;
            mv_ins_next = 1'b1;
          end
          ACT_CHAR: begin
            if (length < CAP_M1) begin
              mv_cnt_next = length;
              mv_ins_next = 1'b1;
            end else begin
              ovf_next = 1'b1;  // dropped, last slot kept for newline
            end
          end
          default: begin
          end
        endcase
      end
      ST_MOVE: begin
        // write back the character read last cycle, issue the next read
        if (wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = mem_rdata;
        end
        if (mv_more) begin
          mem_re       = 1'b1;
          wr_pend_next = 1'b1;
          if (mv_ins) begin
            mem_raddr    = ADDR_W'(mv_cnt - ONE);
            wr_addr_next = ADDR_W'(mv_cnt);
            mv_cnt_next  = mv_cnt - ONE;
          end else begin
            mem_raddr    = ADDR_W'(mv_cnt);
            wr_addr_next = ADDR_W'(mv_cnt - ONE);
            mv_cnt_next  = mv_cnt + ONE;
          end
        end else begin
          wr_pend_next = 1'b0;
        end
      end
      ST_INS_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = ADDR_W'(cursor);
        mem_wdata     = code;
        cursor_next   = cursor + ONE;
        length_next   = length + ONE;
        line_idx_next = '0;
      end
      ST_LINE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(line_idx);
      end
      ST_LINE_OUT: begin
        if (slot_free) begin
          load_out    = 1'b1;
          o_kind_next = 1'b1;
          o_char_next = mem_rdata;
          o_last_next = line_last;
          if (line_last) begin
            cursor_next = '0;
            length_next = '0;
          end else begin
            line_idx_next = line_idx + ONE;
            mem_re        = 1'b1;
            mem_raddr     = ADDR_W'(line_idx + ONE);
          end
        end
      end
      ST_STATUS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(cursor);
      end
      ST_STATUS_OUT: begin
        if (slot_free) begin
          load_out    = 1'b1;
          o_char_next = (cursor < length) ? mem_rdata : SPACE_CODE;
          o_cur_next  = POS_W'(cursor);
          o_len_next  = POS_W'(length);
          o_ovf_next  = ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor    <= '0;
      length    <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      length    <= length_next;
      wr_pend   <= wr_pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bs_code    <= BACKSPACE_RST;
      del_code   <= DELETE_RST;
      left_code  <= LEFT_RST;
      right_code <= RIGHT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BACKSPACE: bs_code    <= cfg_data;
        REG_DELETE:    del_code   <= cfg_data;
        REG_LEFT:      left_code  <= cfg_data;
        REG_RIGHT:     right_code <= cfg_data;
        default:       bs_code    <= bs_code;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code     <= code_next;
    ovf      <= ovf_next;
    mv_cnt   <= mv_cnt_next;
    mv_ins   <= mv_ins_next;
    wr_addr  <= wr_addr_next;
    line_idx <= line_idx_next;
    if (load_out) begin
      o_kind <= o_kind_next;
      o_char <= o_char_next;
      o_cur  <= o_cur_next;
      o_len  <= o_len_next;
      o_ovf  <= o_ovf_next;
      o_last <= o_last_next;
    end
  end

endmodule

### tb/sv/line_editor_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_buffer_checker: result predictor and scoreboard
// Watches the key, result and config ports. Keeps its own copy of the line,
// cursor and edit codes, predicts the results of every accepted key and
// compares each result taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module line_editor_buffer_checker
  import leb_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          results_awaited
);

  typedef struct packed {
    logic             kind;
    logic [CHAR_W-1:0] char_value;
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  line_length;
    logic             overflow;
    logic             last;
  } editor_result_t;

  logic [CHAR_W-1:0] edit_code [4];
  logic [CHAR_W-1:0] text [LINE_CAPACITY];
  logic [POS_W-1:0]  caret;
  logic [POS_W-1:0]  text_len;
  editor_result_t    awaited_results[$];

  initial begin
    mismatches      = 0;
    results_awaited = 0;
  end

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("%0d ns  %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  function automatic void insert_char(input logic [CHAR_W-1:0] c);
    int i;
    for (i = text_len; i > caret; i--)
      text[i] = text[i-1];
    text[caret] = c;
    caret++;
    text_len++;
  endfunction

  function automatic void drop_char(input int pos);
    int i;
    for (i = pos; i + 1 < text_len; i++)
      text[i] = text[i+1];
    text_len--;
  endfunction

  // one key: update the line, queue the status item or the committed line
  task automatic edit_line(input logic [CHAR_W-1:0] key);
    act_t           act;
    editor_result_t res;
    logic           dropped;
    int             i;
    dropped = 1'b0;
    if (key == edit_code[REG_BACKSPACE])  act = ACT_BS;
    else if (key == edit_code[REG_DELETE]) act = ACT_DEL;
    else if (key == edit_code[REG_LEFT])   act = ACT_LEFT;
    else if (key == edit_code[REG_RIGHT])  act = ACT_RIGHT;
    else if (key == NEWLINE_CODE)          act = ACT_NL;
    else if (key != NUL_CODE)              act = ACT_CHAR;
    else                                   act = ACT_NONE;
    case (act)
      ACT_BS: begin
        if (caret > 0) begin
          drop_char(caret - 1);
          caret--;
        end
      end
      ACT_DEL: begin
        if (caret < text_len) drop_char(caret);
      end
      ACT_LEFT: begin
        if (caret > 0) caret--;
      end
      ACT_RIGHT: begin
        if (caret < text_len) caret++;
      end
      ACT_NL: begin
        if (text_len < LINE_CAPACITY) insert_char(key);
      end
      ACT_CHAR: begin
        // last slot is reserved for the newline
        if (text_len < LINE_CAPACITY - 1) insert_char(key);
        else dropped = 1'b1;
      end
      default: ;
    endcase
    if (act == ACT_NL) begin
      for (i = 0; i < text_len; i++) begin
        res = '{kind: 1'b1, char_value: text[i], cursor_pos: '0, line_length: '0,
                overflow: 1'b0, last: (i + 1 == text_len)};
        awaited_results.push_back(res);
      end
      caret    = '0;
      text_len = '0;
    end else begin
      res.kind        = 1'b0;
      res.char_value  = (caret < text_len) ? text[caret] : SPACE_CODE;
      res.cursor_pos  = caret;
      res.line_length = text_len;
      res.overflow    = dropped;
      res.last        = 1'b1;
      awaited_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    editor_result_t want;
    if (rst) begin
      edit_code[REG_BACKSPACE] = BACKSPACE_RST;
      edit_code[REG_DELETE]    = DELETE_RST;
      edit_code[REG_LEFT]      = LEFT_RST;
      edit_code[REG_RIGHT]     = RIGHT_RST;
      caret    = '0;
      text_len = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) edit_code[cfg_index] = cfg_data;
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("awaited results at output", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser != want.kind)
            flag_mismatch("kind", want.kind, m_tuser);
          if (m_tdata[7:0] != want.char_value)
            flag_mismatch("char_value", want.char_value, m_tdata[7:0]);
          if (m_tdata[14:8] != want.cursor_pos)
            flag_mismatch("cursor_pos", want.cursor_pos, m_tdata[14:8]);
          if (m_tdata[21:15] != want.line_length)
            flag_mismatch("line_length", want.line_length, m_tdata[21:15]);
          if (m_tdata[22] != want.overflow)
            flag_mismatch("overflow", want.overflow, m_tdata[22]);
          if (m_tlast != want.last)
            flag_mismatch("last", want.last, m_tlast);
          if (m_tdata[23] !== 1'b0)
            flag_mismatch("tdata pad bit", 0, m_tdata[23]);
        end
      end
      if (s_tvalid && s_tready) edit_line(s_tdata);
    end
    results_awaited <= awaited_results.size();
  end

endmodule

### tb/sv/line_editor_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_buffer_test: top level testbench for the line editor buffer
// Drives key codes and edit-code writes into the block, idles both stream
// sides at random, and leaves prediction and checking to the checker.
// Runs a directed opener, a full-store line, then random typing sessions
// under several edit-code settings, and reports one verdict.
// ----------------------------------------------------------------------------
module line_editor_buffer_test;
  import leb_pkg::*;

  localparam int LINE_CAPACITY = 64;
  localparam int LONG_HOLD     = 200;     // receiver hold-off, cycles
  localparam int SETTLE_CYCLES = 10;      // idle margin before config writes
  localparam int END_CYCLES    = 80;      // idle margin at the end
  localparam int CYCLE_LIMIT   = 500000;  // watchdog

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;         // [7:0] key_char
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;              // [7:0] char_value, [14:8] cursor_pos,
                                     // [21:15] line_length, [22] overflow
  logic        m_tuser;              // [0] kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_BACKSPACE;
  logic [7:0]  cfg_data = '0;

  int          mismatches;
  int          results_awaited;

  // stimulus-side copy of the edit codes, to aim keys at them
  logic [7:0]  code_of [4];
  logic        jitter_on = 1'b1;     // random idling on both sides
  logic        long_hold_req = 1'b0;
  int          rx_stall = 0;         // cycles left with m_tready low
  int          cycle_count = 0;

  initial forever #1 clk = ~clk;

  line_editor_buffer #(.LINE_CAPACITY(LINE_CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_editor_buffer_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_awaited (results_awaited)
  );

  // Receiver: short random stalls while jitter is on, plus one long hold-off
  // on request so the block backs up into its input.
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      m_tready      <= 1'b0;
      rx_stall      <= LONG_HOLD - 1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_stall <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one key and hold it until the block takes it. Valid stays up
  // into the next key unless a random gap follows.
  task automatic send_key(input logic [7:0] key);
    s_tdata  <= key;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted item, then let the block
  // drop back to idle.
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_code(input reg_idx_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    code_of[idx] = value;
    @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] bs, input logic [7:0] del,
                           input logic [7:0] left, input logic [7:0] right);
    write_code(REG_BACKSPACE, bs);
    write_code(REG_DELETE, del);
    write_code(REG_LEFT, left);
    write_code(REG_RIGHT, right);
    cfg_we <= 1'b0;
  endtask

  // a code that always decodes as a text character: nonzero, not newline, no edit key
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == NEWLINE_CODE || c == code_of[REG_BACKSPACE] ||
           c == code_of[REG_DELETE] || c == code_of[REG_LEFT] ||
           c == code_of[REG_RIGHT]);
    return c;
  endfunction

  // typing mix: mostly printable text and edit keys, some newlines,
  // no-key codes and raw bytes so every key bit toggles
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      return 8'($urandom_range(32, 126));
    else if (r < 75) return code_of[2'($urandom_range(0, 3))];
    else if (r < 83) return NEWLINE_CODE;
    else if (r < 90) return NUL_CODE;
    else             return 8'($urandom_range(0, 255));
  endfunction

  task automatic type_session(input int n);
    repeat (n) send_key(pick_key());
  endtask

  initial begin
    code_of[REG_BACKSPACE] = BACKSPACE_RST;
    code_of[REG_DELETE]    = DELETE_RST;
    code_of[REG_LEFT]      = LEFT_RST;
    code_of[REG_RIGHT]     = RIGHT_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed opener, reset codes ----
    send_key(NUL_CODE);                   // no key on an empty line
    send_key(BACKSPACE_RST);              // backspace at line start
    send_key(DELETE_RST);                 // delete at line end
    send_key(LEFT_RST);                   // left at 0
    send_key(RIGHT_RST);                  // right at the length
    send_key(NEWLINE_CODE);               // empty line commits the newline only
    send_key(8'd97);
    send_key(8'd255);
    send_key(8'd1);
    send_key(8'd128);
    send_key(LEFT_RST);
    send_key(LEFT_RST);
    send_key(DELETE_RST);                 // delete mid-line
    send_key(BACKSPACE_RST);              // backspace mid-line
    send_key(8'd90);                      // insert mid-line, tail shifts
    send_key(RIGHT_RST);
    send_key(RIGHT_RST);                  // right stops at the length
    send_key(NUL_CODE);                   // no key, line kept
    send_key(LEFT_RST);
    send_key(NEWLINE_CODE);               // newline inserted at the cursor

    // ---- full store: fill to capacity-1, overflow at end and mid-line,
    // then a newline into the reserved slot gives the longest line ----
    repeat (LINE_CAPACITY - 1) send_key(pick_plain());
    send_key(pick_plain());
    send_key(pick_plain());
    send_key(code_of[REG_LEFT]);
    send_key(pick_plain());
    send_key(NEWLINE_CODE);

    // random typing; the receiver holds off long enough to back up the input
    long_hold_req <= 1'b1;
    type_session(15);
    drain(SETTLE_CYCLES);

    // extreme codes; backspace on 0 means there is no idle key
    set_codes(8'd0, 8'd255, 8'd254, 8'd1);
    type_session(15);
    drain(SETTLE_CYCLES);

    // every key on one code: backspace wins the priority
    set_codes(8'd255, 8'd255, 8'd255, 8'd255);
    type_session(15);
    drain(SETTLE_CYCLES);

    // newline taken over by delete, so lines never commit here
    set_codes(8'd127, NEWLINE_CODE, 8'd27, 8'd9);
    type_session(15);
    drain(SETTLE_CYCLES);

    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    type_session(15);
    drain(SETTLE_CYCLES);

    // back to the usual codes, both sides at full rate
    set_codes(BACKSPACE_RST, DELETE_RST, LEFT_RST, RIGHT_RST);
    jitter_on = 1'b0;
    type_session(15);
    send_key(NEWLINE_CODE);
    drain(END_CYCLES);

    if (mismatches == 0 && results_awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/leb_pkg.sv
rtl/leb_store.sv
rtl/line_editor_buffer.sv
tb/sv/line_editor_buffer_checker.sv
tb/sv/line_editor_buffer_test.sv
